FILE: rtl/core/tilt_orientation_detector_defines.svh
// ----------------------------------------------------------------------------
// tilt orientation detector assertion macros
// shared property forms for the detector's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TILT_ORIENTATION_DETECTOR_DEFINES_SVH
`define TILT_ORIENTATION_DETECTOR_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TOD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tod assertion failed");

// next-cycle implication
`define TOD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tod assertion failed");

`endif

FILE: rtl/core/tod_pkg.sv
// ----------------------------------------------------------------------------
// tod_pkg
// constants, register indexes, orientation codes and control structs
// ----------------------------------------------------------------------------
package tod_pkg;

	localparam int TIME_WIDTH_DEF        = 32;
	localparam int SAMPLE_WIDTH_DEF      = 16;
	localparam int FILTER_EXTRA_FRAC_DEF = 8;

	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int POLL_W     = 16;
	localparam int SETTLE_W   = 16;
	localparam int ALPHA_W    = 16;
	localparam int TILT_W     = 15;
	localparam int RATIO_W    = 14;
	localparam int TILT_SQ_W  = 2 * TILT_W;
	localparam int ALPHA_FRAC = 16;
	localparam int RATIO_FRAC = 12;

	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TILT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOM_RATIO     = 3'd4;

	localparam logic [POLL_W-1:0]   POLL_RESET   = 16'd100;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd5000;
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd6554;
	localparam logic [TILT_W-1:0]   TILT_RESET   = 15'd1434;
	localparam logic [RATIO_W-1:0]  RATIO_RESET  = 14'd5325;

	localparam logic [2:0] ORIENT_Y_POS = 3'd0;
	localparam logic [2:0] ORIENT_X_NEG = 3'd1;
	localparam logic [2:0] ORIENT_Y_NEG = 3'd2;
	localparam logic [2:0] ORIENT_X_POS = 3'd3;
	localparam logic [2:0] ORIENT_NONE  = 3'd4;

	typedef struct packed {
		logic load;
		logic seed;
		logic mul;
		logic add;
		logic sq;
	} lane_ctl_t;

	typedef struct packed {
		logic take_new;
		logic commit;
	} decision_t;

endpackage

FILE: rtl/core/tod_lane.sv
// ----------------------------------------------------------------------------
// tod_lane
// one axis: low pass filter step, then magnitude, square and ratio product
// ----------------------------------------------------------------------------
module tod_lane #(
	parameter int SAMPLE_WIDTH      = tod_pkg::SAMPLE_WIDTH_DEF,
	parameter int FILTER_EXTRA_FRAC = tod_pkg::FILTER_EXTRA_FRAC_DEF
) (
	input  logic                                     clk,
	input  tod_pkg::lane_ctl_t                       ctl,
	input  logic signed [SAMPLE_WIDTH-1:0]           g,
	input  logic [tod_pkg::ALPHA_W-1:0]              alpha,
	input  logic [tod_pkg::RATIO_W-1:0]              ratio,
	output logic [SAMPLE_WIDTH-1:0]                  mag,
	output logic [2*SAMPLE_WIDTH-1:0]                sq,
	output logic [SAMPLE_WIDTH+tod_pkg::RATIO_W-1:0] rat,
	output logic                                     pos
);

	localparam int SW = SAMPLE_WIDTH + FILTER_EXTRA_FRAC;
	localparam int DW = SW + 1;
	localparam int PW = DW + tod_pkg::ALPHA_W + 1;
	localparam int QW = 2 * SAMPLE_WIDTH;
	localparam int RW = SAMPLE_WIDTH + tod_pkg::RATIO_W;
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (tod_pkg::ALPHA_FRAC - 1);

	logic signed [SW-1:0]           target_in;
	logic signed [SW-1:0]           target_q;
	logic                           seed_q;
	logic signed [SW-1:0]           s_q;
	logic signed [DW-1:0]           diff_s1;
	logic signed [PW-1:0]           alpha_ext;
	logic signed [PW-1:0]           prod_c;
	logic signed [PW-1:0]           prod_s2;
	logic signed [PW-1:0]           rnd_c;
	logic signed [SAMPLE_WIDTH-1:0] x_c;
	logic [SAMPLE_WIDTH-1:0]        mag_c;
	logic [SAMPLE_WIDTH-1:0]        mag_s3;
	logic [QW-1:0]                  sq_s3;
	logic [RW-1:0]                  rat_s3;
	logic                           pos_s3;

	assign target_in = SW'(g) <<< FILTER_EXTRA_FRAC;
	assign alpha_ext = PW'(alpha);
	assign prod_c    = PW'(diff_s1) * alpha_ext;
	// floor of (prod + half) / 2^16, ties go up
	assign rnd_c     = (prod_s2 + ROUND_HALF) >>> tod_pkg::ALPHA_FRAC;

	// drop the extra fraction bits with a floor
	assign x_c   = s_q[SW-1:FILTER_EXTRA_FRAC];
	assign mag_c = x_c[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-x_c) : SAMPLE_WIDTH'(x_c);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			target_q <= target_in;
			seed_q   <= ctl.seed;
			diff_s1  <= DW'(target_in) - DW'(s_q);
		end
		if (ctl.mul) begin
			prod_s2 <= prod_c;
		end
		if (ctl.add) begin
			s_q <= seed_q ? target_q : s_q + SW'(rnd_c);
		end
		if (ctl.sq) begin
			mag_s3 <= mag_c;
			sq_s3  <= QW'(mag_c) * QW'(mag_c);
			rat_s3 <= RW'(mag_c) * RW'(ratio);
			pos_s3 <= !x_c[SAMPLE_WIDTH-1] && (x_c != '0);
		end
	end

	assign mag = mag_s3;
	assign sq  = sq_s3;
	assign rat = rat_s3;
	assign pos = pos_s3;

endmodule

FILE: rtl/core/tod_merge.sv
// ----------------------------------------------------------------------------
// tod_merge
// combines both lanes into an orientation and decides on candidate and commit
// ----------------------------------------------------------------------------
module tod_merge #(
	parameter int SAMPLE_WIDTH = tod_pkg::SAMPLE_WIDTH_DEF,
	parameter int TIME_WIDTH   = tod_pkg::TIME_WIDTH_DEF
) (
	input  logic [SAMPLE_WIDTH-1:0]                  mag_x,
	input  logic [SAMPLE_WIDTH-1:0]                  mag_y,
	input  logic [2*SAMPLE_WIDTH-1:0]                sq_x,
	input  logic [2*SAMPLE_WIDTH-1:0]                sq_y,
	input  logic [SAMPLE_WIDTH+tod_pkg::RATIO_W-1:0] rat_x,
	input  logic [SAMPLE_WIDTH+tod_pkg::RATIO_W-1:0] rat_y,
	input  logic                                     pos_x,
	input  logic                                     pos_y,
	input  logic [tod_pkg::TILT_SQ_W-1:0]            tilt_sq,
	input  logic [TIME_WIDTH-1:0]                    now,
	input  logic [2:0]                               pending,
	input  logic [TIME_WIDTH-1:0]                    pending_start,
	input  logic [tod_pkg::SETTLE_W-1:0]             settle,
	input  logic [1:0]                               rotation,
	input  logic                                     blocked,
	output logic [2:0]                               cand,
	output tod_pkg::decision_t                       dec
);

	localparam int QW = 2 * SAMPLE_WIDTH + 1;
	localparam int CW = (QW > tod_pkg::TILT_SQ_W) ? QW : tod_pkg::TILT_SQ_W;
	localparam int RW = SAMPLE_WIDTH + tod_pkg::RATIO_W;

	logic [CW-1:0]         sum_c;
	logic [RW-1:0]         scaled_x;
	logic [RW-1:0]         scaled_y;
	logic [TIME_WIDTH-1:0] age_c;
	logic                  settled;

	assign sum_c    = CW'(sq_x) + CW'(sq_y);
	assign scaled_x = RW'(mag_x) << tod_pkg::RATIO_FRAC;
	assign scaled_y = RW'(mag_y) << tod_pkg::RATIO_FRAC;

	always_comb begin
		if (sum_c < CW'(tilt_sq)) begin
			cand = tod_pkg::ORIENT_NONE;
		end else if (mag_y > mag_x) begin
			if (scaled_y < rat_x) begin
				cand = tod_pkg::ORIENT_NONE;
			end else begin
				cand = pos_y ? tod_pkg::ORIENT_Y_POS : tod_pkg::ORIENT_Y_NEG;
			end
		end else begin
			// equal axes land here as well
			if (scaled_x < rat_y) begin
				cand = tod_pkg::ORIENT_NONE;
			end else begin
				cand = pos_x ? tod_pkg::ORIENT_X_POS : tod_pkg::ORIENT_X_NEG;
			end
		end
	end

	// settle age wraps with the time base
	assign age_c   = now - pending_start;
	assign settled = age_c >= TIME_WIDTH'(settle);

	always_comb begin
		dec.take_new = (cand != tod_pkg::ORIENT_NONE) && (cand != pending);
		dec.commit   = (cand != tod_pkg::ORIENT_NONE) && (cand == pending)
			&& (pending[1:0] != rotation) && settled && !blocked;
	end

endmodule

FILE: rtl/core/tilt_orientation_detector.sv
// ----------------------------------------------------------------------------
// tilt_orientation_detector
// Turns timestamped gravity samples into screen rotation commits.
// Config: cfg_we writes cfg_data to the register at cfg_index on a rising
// edge; write only while no transaction is in flight.
// Input channel item_valid/item_stall carries one sample transaction; the
// block raises item_stall while it works on one, so one item is in flight.
// A filtered sample passes the lane sequence difference, alpha multiply,
// filter add, square/ratio multiply before result_valid; merge and
// decision sit in front of the output register.
// Disabled, too-early or failed samples skip the lanes and give an all-zero
// result. item_stall drops as the result is registered, so a filtered item
// passes the MUL, ADD, SQ and OUT states and a skipped one only OUT.
// Output channel result_valid/result_stall: a stalled result holds, and the
// next item is still accepted; its result waits until the register frees.
// Reset loads the default registers, clears the filter seed and the pending
// rotation, and leaves both channels empty.
// ----------------------------------------------------------------------------
`include "tilt_orientation_detector_defines.svh"

module tilt_orientation_detector #(
	parameter int TIME_WIDTH        = tod_pkg::TIME_WIDTH_DEF,
	parameter int SAMPLE_WIDTH      = tod_pkg::SAMPLE_WIDTH_DEF,
	parameter int FILTER_EXTRA_FRAC = tod_pkg::FILTER_EXTRA_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tod_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tod_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            enable,
	input  logic                            sample_valid,
	input  logic signed [SAMPLE_WIDTH-1:0]  gravity_x,
	input  logic signed [SAMPLE_WIDTH-1:0]  gravity_y,
	input  logic [TIME_WIDTH-1:0]           time_ms,
	input  logic [1:0]                      current_rotation,
	input  logic                            ui_blocked,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            commit,
	output logic [1:0]                      new_rotation,
	output logic                            candidate_changed
);

	localparam int RW = SAMPLE_WIDTH + tod_pkg::RATIO_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [tod_pkg::POLL_W-1:0]    poll_q;
	logic [tod_pkg::SETTLE_W-1:0]  settle_q;
	logic [tod_pkg::ALPHA_W-1:0]   alpha_q;
	logic [tod_pkg::TILT_W-1:0]    tilt_q;
	logic [tod_pkg::RATIO_W-1:0]   ratio_q;

	logic [2:0]                    state_q;
	logic                          zero_q;
	logic                          seeded_q;
	logic [2:0]                    pending_q;
	logic [TIME_WIDTH-1:0]         pending_start_q;
	logic [TIME_WIDTH-1:0]         last_poll_q;
	logic [TIME_WIDTH-1:0]         now_q;
	logic [1:0]                    rot_q;
	logic                          blk_q;
	logic [tod_pkg::TILT_SQ_W-1:0] tilt_sq_s3;

	logic                          result_valid_q;
	logic                          commit_q;
	logic [1:0]                    new_rot_q;
	logic                          changed_q;

	logic                          accept;
	logic                          too_soon;
	logic                          full_path;
	logic                          out_load;
	tod_pkg::lane_ctl_t            lane_ctl;
	tod_pkg::decision_t            dec;
	logic [2:0]                    cand;

	logic [SAMPLE_WIDTH-1:0]       mag_x, mag_y;
	logic [2*SAMPLE_WIDTH-1:0]     sq_x, sq_y;
	logic [RW-1:0]                 rat_x, rat_y;
	logic                          pos_x, pos_y;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign too_soon   = (time_ms - last_poll_q) < TIME_WIDTH'(poll_q);
	assign full_path  = enable && !too_soon && sample_valid;
	assign out_load   = (state_q == ST_OUT) && (!result_valid_q || !result_stall);

	always_comb begin
		lane_ctl.load = accept && full_path;
		lane_ctl.seed = !seeded_q;
		lane_ctl.mul  = (state_q == ST_MUL);
		lane_ctl.add  = (state_q == ST_ADD);
		lane_ctl.sq   = (state_q == ST_SQ);
	end

	tod_lane #(
		.SAMPLE_WIDTH      (SAMPLE_WIDTH),
		.FILTER_EXTRA_FRAC (FILTER_EXTRA_FRAC)
	) u_lane_x (
		.clk   (clk),
		.ctl   (lane_ctl),
		.g     (gravity_x),
		.alpha (alpha_q),
		.ratio (ratio_q),
		.mag   (mag_x),
		.sq    (sq_x),
		.rat   (rat_x),
		.pos   (pos_x)
	);

	tod_lane #(
		.SAMPLE_WIDTH      (SAMPLE_WIDTH),
		.FILTER_EXTRA_FRAC (FILTER_EXTRA_FRAC)
	) u_lane_y (
		.clk   (clk),
		.ctl   (lane_ctl),
		.g     (gravity_y),
		.alpha (alpha_q),
		.ratio (ratio_q),
		.mag   (mag_y),
		.sq    (sq_y),
		.rat   (rat_y),
		.pos   (pos_y)
	);

	tod_merge #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_merge (
		.mag_x         (mag_x),
		.mag_y         (mag_y),
		.sq_x          (sq_x),
		.sq_y          (sq_y),
		.rat_x         (rat_x),
		.rat_y         (rat_y),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.tilt_sq       (tilt_sq_s3),
		.now           (now_q),
		.pending       (pending_q),
		.pending_start (pending_start_q),
		.settle        (settle_q),
		.rotation      (rot_q),
		.blocked       (blk_q),
		.cand          (cand),
		.dec           (dec)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q   <= tod_pkg::POLL_RESET;
			settle_q <= tod_pkg::SETTLE_RESET;
			alpha_q  <= tod_pkg::ALPHA_RESET;
			tilt_q   <= tod_pkg::TILT_RESET;
			ratio_q  <= tod_pkg::RATIO_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tod_pkg::REG_POLL_INTERVAL: poll_q   <= cfg_data[tod_pkg::POLL_W-1:0];
				tod_pkg::REG_SETTLE:        settle_q <= cfg_data[tod_pkg::SETTLE_W-1:0];
				tod_pkg::REG_FILTER_ALPHA:  alpha_q  <= cfg_data[tod_pkg::ALPHA_W-1:0];
				tod_pkg::REG_MIN_TILT:      tilt_q   <= cfg_data[tod_pkg::TILT_W-1:0];
				tod_pkg::REG_DOM_RATIO:     ratio_q  <= cfg_data[tod_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			zero_q          <= 1'b1;
			seeded_q        <= 1'b0;
			pending_q       <= tod_pkg::ORIENT_NONE;
			pending_start_q <= '0;
			last_poll_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!enable) begin
							pending_q <= tod_pkg::ORIENT_NONE;
							seeded_q  <= 1'b0;
							zero_q    <= 1'b1;
							state_q   <= ST_OUT;
						end else if (too_soon) begin
							zero_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							last_poll_q <= time_ms;
							if (sample_valid) begin
								seeded_q <= 1'b1;
								zero_q   <= 1'b0;
								state_q  <= ST_MUL;
							end else begin
								zero_q  <= 1'b1;
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (!zero_q && dec.take_new) begin
							pending_q       <= cand;
							pending_start_q <= now_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-transaction side inputs and the tilt threshold square
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= time_ms;
			rot_q <= current_rotation;
			blk_q <= ui_blocked;
		end
		if (state_q == ST_SQ) begin
			tilt_sq_s3 <= tod_pkg::TILT_SQ_W'(tilt_q) * tod_pkg::TILT_SQ_W'(tilt_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			commit_q  <= !zero_q && dec.commit;
			new_rot_q <= (!zero_q && dec.commit) ? pending_q[1:0] : 2'd0;
			changed_q <= !zero_q && dec.take_new;
		end
	end

	assign result_valid      = result_valid_q;
	assign commit            = commit_q;
	assign new_rotation      = new_rot_q;
	assign candidate_changed = changed_q;

	`TOD_ASSERT_NEXT(a_accept_leaves_idle, item_valid && !item_stall, state_q != ST_IDLE)
	`TOD_ASSERT_IMPL(a_commit_not_new, result_valid && commit, !candidate_changed)
	`TOD_ASSERT_IMPL(a_rot_only_on_commit, result_valid && !commit, new_rotation == 2'd0)
	`TOD_ASSERT_IMPL(a_pending_code, 1'b1, pending_q <= tod_pkg::ORIENT_NONE)

endmodule
